// ===== sv/wtrm_pkg.sv =====
// Package: shared types and constants for the windowed transfer rate meter.
package wtrm_pkg;

	localparam logic [1:0] REQ_RECORD = 2'd0;
	localparam logic [1:0] REQ_SPEED  = 2'd1;
	localparam logic [1:0] REQ_WINDOW = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	localparam logic CFG_INTERVAL = 1'b0;
	localparam logic CFG_SLOTS    = 1'b1;

	localparam logic [15:0] INTERVAL_RST = 16'd100;
	localparam logic [4:0]  SLOTS_RST    = 5'd10;
	localparam logic [9:0]  MS_PER_S     = 10'd1000;
	localparam logic [31:0] NO_START     = 32'hFFFF_FFFF;

	// datapath operations issued by the controller
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_DIV1    = 4'd2;
	localparam logic [3:0] OP_DIV2    = 4'd3;
	localparam logic [3:0] OP_SCAN    = 4'd4;
	localparam logic [3:0] OP_WRITE   = 4'd5;
	localparam logic [3:0] OP_CLEAR   = 4'd6;
	localparam logic [3:0] OP_PREP    = 4'd7;
	localparam logic [3:0] OP_DIV3    = 4'd8;
	localparam logic [3:0] OP_RESULT  = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic       first;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic scan_done;
		logic clear_done;
	} stat_t;

endpackage

// ===== sv/wtrm_ctrl.sv =====
// Controller: sequences one request through divide, scan, write, clear and result steps.
module wtrm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          req_type,
	input  logic                zero_bytes,
	input  logic                out_busy,
	input  wtrm_pkg::stat_t     stat,
	output logic                in_stall,
	output wtrm_pkg::cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV1  = 4'd1;
	localparam logic [3:0] ST_SCAN  = 4'd2;
	localparam logic [3:0] ST_WRITE = 4'd3;
	localparam logic [3:0] ST_CLEAR = 4'd4;
	localparam logic [3:0] ST_PREP  = 4'd5;
	localparam logic [3:0] ST_DIV3  = 4'd6;
	localparam logic [3:0] ST_RES   = 4'd7;
	localparam logic [3:0] ST_DIV2  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       first_q;
	logic [1:0] req_q;

	assign in_stall = (state_q != ST_IDLE);

	// next state and command
	always_comb begin
		state_d   = state_q;
		cmd.op    = wtrm_pkg::OP_NONE;
		cmd.first = first_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = wtrm_pkg::OP_LOAD;
					if (req_type == wtrm_pkg::REQ_CLEAR)
						state_d = ST_CLEAR;
					else if (req_type == wtrm_pkg::REQ_RECORD && zero_bytes)
						state_d = ST_IDLE;
					else
						state_d = ST_DIV1;
				end
			end
			ST_DIV1: begin
				cmd.op = wtrm_pkg::OP_DIV1;
				if (stat.div_done)
					state_d = (req_q == wtrm_pkg::REQ_WINDOW) ? ST_DIV2 : ST_SCAN;
			end
			ST_DIV2: begin
				cmd.op = wtrm_pkg::OP_DIV2;
				if (stat.div_done) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.op = wtrm_pkg::OP_SCAN;
				if (stat.scan_done) begin
					case (req_q)
						wtrm_pkg::REQ_RECORD: state_d = ST_WRITE;
						wtrm_pkg::REQ_SPEED:  state_d = ST_PREP;
						default:              state_d = ST_RES;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.op  = wtrm_pkg::OP_WRITE;
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.op = wtrm_pkg::OP_CLEAR;
				if (stat.clear_done) state_d = ST_IDLE;
			end
			ST_PREP: begin
				cmd.op  = wtrm_pkg::OP_PREP;
				state_d = ST_DIV3;
			end
			ST_DIV3: begin
				cmd.op = wtrm_pkg::OP_DIV3;
				if (stat.div_done) state_d = ST_RES;
			end
			ST_RES: begin
				if (!out_busy) begin
					cmd.op  = wtrm_pkg::OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register, request type and first cycle marker for iterative steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
			req_q   <= wtrm_pkg::REQ_RECORD;
		end else begin
			state_q <= state_d;
			first_q <= (state_d != state_q);
			if (state_q == ST_IDLE && in_valid) req_q <= req_type;
		end
	end

endmodule

// ===== sv/wtrm_dp.sv =====
// Datapath: slot store, shared restoring divider, scan, result register.
module wtrm_dp #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wtrm_pkg::cmd_t      cmd,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          req_type,
	input  logic [31:0]         tick_ms,
	input  logic [63:0]         byte_count,
	input  logic [30:0]         window_ms,
	input  logic                out_stall,
	output wtrm_pkg::stat_t     stat,
	output logic                out_busy,
	output logic                out_valid,
	output logic                result_kind,
	output logic [31:0]         speed_bps,
	output logic [63:0]         window_bytes,
	output logic [31:0]         window_start
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam logic [CW-1:0] MAXN = CW'(MAX_SLOTS);
	localparam logic [63:0] MS_PER_S_W = 64'(wtrm_pkg::MS_PER_S);

	logic [15:0]  interval_q;
	logic [4:0]   slots_q;
	logic [31:0]  time_q [MAX_SLOTS];
	logic [63:0]  bytes_q [MAX_SLOTS];
	logic [IW-1:0] newest_q;

	logic [1:0]   req_q;
	logic [31:0]  tick_q;
	logic [63:0]  add_q;
	logic [30:0]  win_q;
	logic [31:0]  cur_q;
	logic [31:0]  floor_q;
	logic [63:0]  sum_q;
	logic [31:0]  start_q;
	logic         hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [CW-1:0] cnt_q;

	// divider: 64-bit dividend, 64-bit divisor, one quotient bit a cycle
	logic [63:0]  dnum_q, dden_q, dquo_q;
	logic [64:0]  drem_q;
	logic [6:0]   dbit_q;
	logic [64:0]  trial;

	logic [15:0]  iv;
	logic [CW-1:0] n_eff;
	logic [4:0]   n_sat;
	logic [IW-1:0] scan_idx;
	logic [31:0]  span;
	logic [63:0]  scaled;
	logic [IW-1:0] wr_idx;
	logic [IW-1:0] nxt;

	assign iv = (interval_q == 16'd0) ? 16'd1 : interval_q;
	assign n_sat = (slots_q == 5'd0) ? 5'd1 : slots_q;
	assign n_eff = (32'(n_sat) > MAX_SLOTS) ? MAXN : CW'(n_sat);
	assign scan_idx = cnt_q[IW-1:0];
	assign trial = {drem_q[63:0], dnum_q[63]} - {1'b0, dden_q};
	assign span = cur_q - start_q;
	assign scaled = sum_q * MS_PER_S_W;
	assign wr_idx = hit_q ? hit_idx_q :
		((CW'(newest_q) < n_eff) ? newest_q : '0);
	assign nxt = wr_idx + 1'b1;

	assign stat.div_done   = !cmd.first && (dbit_q == 7'd0);
	assign stat.scan_done  = !cmd.first && (cnt_q == n_eff - 1'b1);
	assign stat.clear_done = 1'b1;
	assign out_busy = out_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= wtrm_pkg::INTERVAL_RST;
			slots_q    <= wtrm_pkg::SLOTS_RST;
		end else if (cfg_we) begin
			if (cfg_idx == wtrm_pkg::CFG_INTERVAL) interval_q <= cfg_data;
			else slots_q <= cfg_data[4:0];
		end
	end

	// slot store and ring pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				time_q[i]  <= '0;
				bytes_q[i] <= '0;
			end
		end else if (cmd.op == wtrm_pkg::OP_CLEAR) begin
			newest_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				time_q[i]  <= '0;
				bytes_q[i] <= '0;
			end
		end else if (cmd.op == wtrm_pkg::OP_WRITE) begin
			if (hit_q) begin
				bytes_q[wr_idx] <= bytes_q[wr_idx] + add_q;
			end else begin
				time_q[wr_idx]  <= cur_q;
				bytes_q[wr_idx] <= add_q;
				newest_q <= (CW'(nxt) >= n_eff || nxt == '0) ? '0 : nxt;
			end
		end
	end

	// request operands, divider, scan
	always_ff @(posedge clk) begin
		case (cmd.op)
			wtrm_pkg::OP_LOAD: begin
				req_q  <= req_type;
				tick_q <= tick_ms;
				add_q  <= byte_count;
				win_q  <= window_ms;
			end
			wtrm_pkg::OP_DIV1, wtrm_pkg::OP_DIV2, wtrm_pkg::OP_DIV3: begin
				if (cmd.first) begin
					case (cmd.op)
						wtrm_pkg::OP_DIV1: begin
							dnum_q <= {32'd0, tick_q};
							dden_q <= {48'd0, iv};
							dbit_q <= 7'd32;
						end
						wtrm_pkg::OP_DIV2: begin
							dnum_q <= {33'd0, win_q};
							dden_q <= {48'd0, iv};
							dbit_q <= 7'd31;
						end
						default: begin
							dnum_q <= scaled;
							dden_q <= 64'(span) * 64'(iv);
							dbit_q <= 7'd64;
						end
					endcase
					drem_q <= '0;
					dquo_q <= '0;
					if (cmd.op == wtrm_pkg::OP_DIV1 || cmd.op == wtrm_pkg::OP_DIV2) begin
						dnum_q <= (cmd.op == wtrm_pkg::OP_DIV1) ? {tick_q, 32'd0} :
							{win_q, 33'd0};
					end
				end else if (dbit_q != 7'd0) begin
					if (!trial[64]) drem_q <= trial;
					else drem_q <= {drem_q[63:0], dnum_q[63]};
					dquo_q <= {dquo_q[62:0], !trial[64]};
					dnum_q <= {dnum_q[62:0], 1'b0};
					dbit_q <= dbit_q - 7'd1;
				end else if (cmd.op == wtrm_pkg::OP_DIV1) begin
					cur_q   <= dquo_q[31:0];
					floor_q <= dquo_q[31:0] - 32'(n_eff);
				end else if (cmd.op == wtrm_pkg::OP_DIV2) begin
					floor_q <= cur_q - dquo_q[31:0];
				end
			end
			wtrm_pkg::OP_SCAN: begin
				if (cmd.first) begin
					cnt_q   <= '0;
					sum_q   <= '0;
					start_q <= wtrm_pkg::NO_START;
					hit_q   <= 1'b0;
				end else begin
					if (req_q == wtrm_pkg::REQ_RECORD) begin
						if (!hit_q && time_q[scan_idx] == cur_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= scan_idx;
						end
					end else if (time_q[scan_idx] >= floor_q) begin
						sum_q <= sum_q + bytes_q[scan_idx];
						if (time_q[scan_idx] < start_q) start_q <= time_q[scan_idx];
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.op == wtrm_pkg::OP_RESULT) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == wtrm_pkg::OP_RESULT) begin
			if (req_q == wtrm_pkg::REQ_SPEED) begin
				result_kind  <= 1'b0;
				speed_bps    <= (cur_q > start_q && dden_q != 64'd0) ? dquo_q[31:0] : 32'd0;
				window_bytes <= '0;
				window_start <= '0;
			end else begin
				result_kind  <= 1'b1;
				speed_bps    <= '0;
				window_bytes <= sum_q;
				window_start <= start_q;
			end
		end
	end

endmodule

// ===== sv/windowed_transfer_rate_meter_core.sv =====
// Windowed transfer rate meter: a ring of up to MAX_SLOTS time slots with
// byte counts. Record transfers and speed and window queries are paced by the
// shared one-bit-a-cycle divider (32 steps for the slot number, 31 for the
// window, 64 for bytes per second) and the slot scan that reads one slot a
// cycle. Clear requests skip the divider and the scan, and zero-byte records
// are dropped in idle without either.
// One request is in work at a time; the input stalls until it completes.
module windowed_transfer_rate_meter_core #(
	parameter int MAX_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] tick_ms,
	input  logic [63:0] byte_count,
	input  logic [30:0] window_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [31:0] speed_bps,
	output logic [63:0] window_bytes,
	output logic [31:0] window_start
);

	wtrm_pkg::cmd_t  cmd;
	wtrm_pkg::stat_t stat;
	logic            out_busy;

	wtrm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .req_type(req_type),
		.zero_bytes(byte_count == 64'd0), .out_busy(out_busy), .stat(stat),
		.in_stall(in_stall), .cmd(cmd)
	);

	wtrm_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req_type(req_type), .tick_ms(tick_ms),
		.byte_count(byte_count), .window_ms(window_ms), .out_stall(out_stall),
		.stat(stat), .out_busy(out_busy), .out_valid(out_valid),
		.result_kind(result_kind), .speed_bps(speed_bps),
		.window_bytes(window_bytes), .window_start(window_start)
	);

endmodule
